// ===== hdl/rpa_pkg.sv =====
package rpa_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int COORD_WIDTH   = 32;
  localparam int NUM_STAGES    = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;

  // CORDIC datapath in Q2.30 with headroom
  localparam int CW      = 34;
  localparam int ANGLE_W = 18;
  localparam int RED_W   = 17;
  localparam int PHASE_W = 32;

  localparam int FULL_TURN   = 92160;
  localparam int RECIP_45    = 186414;   // ceil(2^23 / 45)
  localparam int RECIP_45_SH = 23;
  localparam int STEP_45     = 46603;    // floor(2^21 / 45)
  localparam int FRAC_MUL    = 17;       // 2^21 mod 45
  localparam int FRAC_ADD    = 22;       // rounding half turn, scaled
  localparam int RECIP_SMALL = 1457;     // ceil(2^16 / 45)
  localparam logic signed [CW-1:0] INV_GAIN = CW'(652032874);

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_e;

  typedef struct packed {
    axis_e                   axis;
    logic [COORD_WIDTH-1:0]  x;
    logic [COORD_WIDTH-1:0]  y;
    logic [COORD_WIDTH-1:0]  z;
  } point_t;

  typedef struct packed {
    point_t              pt;
    logic                neg;
    logic [PHASE_W-1:0]  phase;
  } job_t;

  // atan(2^-i) in 2^32-per-turn phase units
  function automatic logic [PHASE_W-1:0] atan_phase(input int i);
    logic [PHASE_W-1:0] v;
    case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/rpa_front.sv =====
module rpa_front import rpa_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  point_t                    pt_i,
  input  logic signed [ANGLE_W-1:0] angle_i,
  output logic                      job_valid_o,
  input  logic                      job_ready_i,
  output job_t                      job_o
);

  logic en;
  logic s0_v_q, s1_v_q, s2_v_q, s3_v_q;
  point_t s0_pt_q, s1_pt_q, s2_pt_q;
  logic [RED_W-1:0] s0_r_q, s1_r_q;
  logic [10:0] s1_a_q, s2_a_q;
  logic [5:0]  s2_b_q;
  job_t s3_job_q;

  logic signed [ANGLE_W:0] red;
  logic [34:0] a_prod;
  logic [RED_W-1:0] b_diff;
  logic [20:0] frac_prod;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_fold;
  logic neg;

  // advance the whole front when its last stage is empty or moves on
  assign en          = !s3_v_q || job_ready_i;
  assign in_ready_o  = en;
  assign job_valid_o = s3_v_q;
  assign job_o       = s3_job_q;

  // wrap the angle into one turn
  always_comb begin
    red = {angle_i[ANGLE_W-1], angle_i};
    if (red < 0) red = red + (ANGLE_W+1)'(FULL_TURN);
    if (red < 0) red = red + (ANGLE_W+1)'(FULL_TURN);
    if (red >= (ANGLE_W+1)'(FULL_TURN)) red = red - (ANGLE_W+1)'(FULL_TURN);
  end

  // split r = 45*a + b, then phase = a*2^21 + round share of b
  assign a_prod    = 35'(s0_r_q) * 35'(RECIP_45);
  assign b_diff    = s1_r_q - RED_W'(s1_a_q) * RED_W'(45);
  assign frac_prod = (21'(s2_b_q) * 21'(FRAC_MUL) + 21'(FRAC_ADD)) * 21'(RECIP_SMALL);

  always_comb begin
    phase = {s2_a_q, 21'd0} + PHASE_W'(s2_b_q * 22'(STEP_45))
          + PHASE_W'(frac_prod[20:16]);
    phase_fold = phase;
    neg = 1'b0;
    // fold the middle quadrants onto the outer ones
    if (phase[PHASE_W-1] ^ phase[PHASE_W-2]) begin
      phase_fold[PHASE_W-1] = ~phase[PHASE_W-1];
      neg = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= in_valid_i;
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_pt_q        <= pt_i;
      s0_r_q         <= red[RED_W-1:0];
      s1_pt_q        <= s0_pt_q;
      s1_r_q         <= s0_r_q;
      s1_a_q         <= a_prod[RECIP_45_SH+10:RECIP_45_SH];
      s2_pt_q        <= s1_pt_q;
      s2_a_q         <= s1_a_q;
      s2_b_q         <= b_diff[5:0];
      s3_job_q.pt    <= s2_pt_q;
      s3_job_q.neg   <= neg;
      s3_job_q.phase <= phase_fold;
    end
  end

endmodule

// ===== hdl/rpa_fifo.sv =====
module rpa_fifo import rpa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_data_o
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  job_t mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [AW:0]   count_q;
  logic push, pop;

  assign push_ready_o = (count_q != (AW+1)'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // store an incoming transfer
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

endmodule

// ===== hdl/rpa_back.sv =====
module rpa_back import rpa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  output logic                   job_ready_o,
  input  job_t                   job_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [COORD_WIDTH-1:0] rot_x_o,
  output logic [COORD_WIDTH-1:0] rot_y_o,
  output logic [COORD_WIDTH-1:0] rot_z_o,
  output logic                   saturated_o
);

  localparam int MAG_W = CW - 1;
  localparam int PW    = COORD_WIDTH + MAG_W;
  localparam int RW    = PW - 30;
  localparam int SUMW  = RW + 2;
  localparam logic signed [SUMW-1:0] SAT_HI =
    {{(SUMW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SUMW-1:0] SAT_LO = ~SAT_HI;

  typedef struct packed {
    point_t               pt;
    logic                 neg;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } rot_t;

  logic en;
  logic st_v_q [NUM_STAGES+1];
  rot_t st_q   [NUM_STAGES+1];

  logic            mul_v_q;
  point_t          mul_pt_q;
  logic [PW-1:0]   m_ac_q, m_bs_q, m_as_q, m_bc_q;
  logic            n_ac_q, n_bs_q, n_as_q, n_bc_q;

  logic            out_v_q;
  logic [COORD_WIDTH-1:0] rx_q, ry_q, rz_q;
  logic            sat_q;

  // stall everything while a finished result waits
  assign en          = !out_v_q || out_ready_i;
  assign job_ready_o = en;
  assign out_valid_o = out_v_q;
  assign rot_x_o     = rx_q;
  assign rot_y_o     = ry_q;
  assign rot_z_o     = rz_q;
  assign saturated_o = sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NUM_STAGES; k++) st_v_q[k] <= 1'b0;
      mul_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      st_v_q[0] <= job_valid_i;
      for (int k = 0; k < NUM_STAGES; k++) st_v_q[k+1] <= st_v_q[k];
      mul_v_q <= st_v_q[NUM_STAGES];
      out_v_q <= mul_v_q;
    end
  end

  // seed the rotator with 1/K and the folded phase
  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0].pt  <= job_i.pt;
      st_q[0].neg <= job_i.neg;
      st_q[0].x   <= INV_GAIN;
      st_q[0].y   <= '0;
      st_q[0].z   <= CW'($signed(job_i.phase));
    end
  end

  // one micro-rotation per stage
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    rot_t nxt;
    logic signed [CW-1:0] ang;
    always_comb begin
      ang = CW'(atan_phase(k));
      nxt = st_q[k];
      if (!st_q[k].z[CW-1]) begin
        nxt.x = $signed(st_q[k].x) - ($signed(st_q[k].y) >>> k);
        nxt.y = $signed(st_q[k].y) + ($signed(st_q[k].x) >>> k);
        nxt.z = $signed(st_q[k].z) - ang;
      end else begin
        nxt.x = $signed(st_q[k].x) + ($signed(st_q[k].y) >>> k);
        nxt.y = $signed(st_q[k].y) - ($signed(st_q[k].x) >>> k);
        nxt.z = $signed(st_q[k].z) + ang;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) st_q[k+1] <= nxt;
    end
  end

  // pick the coordinate pair and form magnitude products
  logic signed [CW-1:0] cos_v, sin_v;
  logic [COORD_WIDTH-1:0] op_a, op_b;
  logic [COORD_WIDTH-1:0] mag_a, mag_b;
  logic [MAG_W-1:0] mag_c, mag_s;
  logic signed [CW-1:0] abs_c, abs_s;

  always_comb begin
    rot_t f;
    f = st_q[NUM_STAGES];
    cos_v = f.neg ? -$signed(f.x) : $signed(f.x);
    sin_v = f.neg ? -$signed(f.y) : $signed(f.y);
    case (f.pt.axis)
      AXIS_X:  begin op_a = f.pt.y; op_b = f.pt.z; end
      AXIS_Y:  begin op_a = f.pt.z; op_b = f.pt.x; end
      AXIS_Z:  begin op_a = f.pt.x; op_b = f.pt.y; end
      default: begin op_a = f.pt.x; op_b = f.pt.y; end
    endcase
    mag_a = op_a[COORD_WIDTH-1] ? (~op_a + 1'b1) : op_a;
    mag_b = op_b[COORD_WIDTH-1] ? (~op_b + 1'b1) : op_b;
    abs_c = cos_v[CW-1] ? -cos_v : cos_v;
    abs_s = sin_v[CW-1] ? -sin_v : sin_v;
    mag_c = abs_c[MAG_W-1:0];
    mag_s = abs_s[MAG_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_pt_q <= st_q[NUM_STAGES].pt;
      m_ac_q   <= PW'(mag_a) * PW'(mag_c);
      m_bs_q   <= PW'(mag_b) * PW'(mag_s);
      m_as_q   <= PW'(mag_a) * PW'(mag_s);
      m_bc_q   <= PW'(mag_b) * PW'(mag_c);
      n_ac_q   <= op_a[COORD_WIDTH-1] ^ cos_v[CW-1];
      n_bs_q   <= op_b[COORD_WIDTH-1] ^ sin_v[CW-1];
      n_as_q   <= op_a[COORD_WIDTH-1] ^ sin_v[CW-1];
      n_bc_q   <= op_b[COORD_WIDTH-1] ^ cos_v[CW-1];
    end
  end

  // round magnitude at 2^-30, halves away from zero, then apply sign
  function automatic logic signed [SUMW-1:0] rnd(input logic [PW-1:0] m, input logic n);
    logic [PW-1:0] t;
    logic signed [SUMW-1:0] r;
    t = m + PW'(1 << 29);
    r = SUMW'(t[PW-1:30]);
    return n ? -r : r;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] clip(input logic signed [SUMW-1:0] v,
                                                  output logic hit);
    hit = 1'b0;
    if (v > SAT_HI) begin
      hit = 1'b1;
      return SAT_HI[COORD_WIDTH-1:0];
    end
    if (v < SAT_LO) begin
      hit = 1'b1;
      return SAT_LO[COORD_WIDTH-1:0];
    end
    return v[COORD_WIDTH-1:0];
  endfunction

  logic signed [SUMW-1:0] na, nb;
  logic [COORD_WIDTH-1:0] ca, cb;
  logic ha, hb;
  logic [COORD_WIDTH-1:0] rx_d, ry_d, rz_d;
  logic sat_d;

  // combine products, saturate and route back to the axes
  always_comb begin
    na = rnd(m_ac_q, n_ac_q) - rnd(m_bs_q, n_bs_q);
    nb = rnd(m_as_q, n_as_q) + rnd(m_bc_q, n_bc_q);
    ca = clip(na, ha);
    cb = clip(nb, hb);
    rx_d  = mul_pt_q.x;
    ry_d  = mul_pt_q.y;
    rz_d  = mul_pt_q.z;
    sat_d = ha | hb;
    case (mul_pt_q.axis)
      AXIS_X:  begin ry_d = ca; rz_d = cb; end
      AXIS_Y:  begin rz_d = ca; rx_d = cb; end
      AXIS_Z:  begin rx_d = ca; ry_d = cb; end
      default: sat_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      rz_q  <= rz_d;
      sat_q <= sat_d;
    end
  end

endmodule

// ===== hdl/rotate_point_about_axis.sv =====
// Rotates a signed Q16.16 point about the X, Y or Z axis by an angle in
// 1/256-degree units (wrapping modulo one turn); axis select 3 passes the
// point through. Sine and cosine come from a 16-stage pipelined CORDIC, and
// rotated coordinates that leave range saturate and raise saturated_o. One
// point is accepted per cycle and one result leaves per cycle unless the
// output stalls; from input transfer to output, four front stages form
// the phase, then the point passes through the four-entry queue, one
// seed stage, one stage per CORDIC step, a multiply stage and the output
// register.
module rotate_point_about_axis import rpa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             axis_select_i,
  input  logic [ANGLE_W-1:0]     angle_i,
  input  logic [COORD_WIDTH-1:0] coord_x_i,
  input  logic [COORD_WIDTH-1:0] coord_y_i,
  input  logic [COORD_WIDTH-1:0] coord_z_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [COORD_WIDTH-1:0] rot_x_o,
  output logic [COORD_WIDTH-1:0] rot_y_o,
  output logic [COORD_WIDTH-1:0] rot_z_o,
  output logic                   saturated_o
);

  point_t pt;
  job_t   f_job, q_job;
  logic   f_valid, f_ready, q_valid, q_ready;

  assign pt.axis = axis_e'(axis_select_i);
  assign pt.x    = coord_x_i;
  assign pt.y    = coord_y_i;
  assign pt.z    = coord_z_i;

  rpa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pt_i        (pt),
    .angle_i     ($signed(angle_i)),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready),
    .job_o       (f_job)
  );

  rpa_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_job),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_job)
  );

  rpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rot_x_o     (rot_x_o),
    .rot_y_o     (rot_y_o),
    .rot_z_o     (rot_z_o),
    .saturated_o (saturated_o)
  );

endmodule

// ===== sim/tb_rotate_point_about_axis.sv =====
module tb_rotate_point_about_axis;
  import rpa_pkg::*;

  localparam int  LIMIT_CYCLES = 300000;
  localparam int  DRAIN_CYCLES = 60;
  localparam longint ONE_TURN  = 92160;

  typedef struct {
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic [COORD_WIDTH-1:0] z;
    logic                   sat;
  } rotated_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [1:0]             axis_select_i = '0;
  logic [ANGLE_W-1:0]     angle_i = '0;
  logic [COORD_WIDTH-1:0] coord_x_i = '0;
  logic [COORD_WIDTH-1:0] coord_y_i = '0;
  logic [COORD_WIDTH-1:0] coord_z_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [COORD_WIDTH-1:0] rot_x_o;
  logic [COORD_WIDTH-1:0] rot_y_o;
  logic [COORD_WIDTH-1:0] rot_z_o;
  logic                   saturated_o;

  rotated_t rotated_q[$];
  int       errors = 0;
  int       points_sent = 0;
  int       points_checked = 0;
  int       sat_seen = 0;
  int       cycle_count = 0;
  int       rx_hold = 0;
  bit       tx_quiet = 0;
  bit       rx_quiet = 0;

  rotate_point_about_axis dut (.*);

  always #5 clk_i = ~clk_i;

  // atan(2^-i) in phase units where 2^32 is one full turn
  function automatic longint arctan_step(input int i);
    longint tbl[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0};
    return tbl[i];
  endfunction

  // round(v * c / 2^30), halves away from zero
  function automatic longint scale_q30(input longint v, input longint c);
    bit                neg;
    longint unsigned   m;
    longint unsigned   k;
    longint unsigned   r;
    neg = (v < 0) != (c < 0);
    m = (v < 0) ? -v : v;
    k = (c < 0) ? -c : c;
    r = (m * k + 64'd536870912) >> 30;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clip_coord(input longint v, inout logic sat);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // cosine and sine of an angle in 1/256 degree, Q2.30, via CORDIC
  function automatic void cordic_trig(input longint ang, output longint c,
                                      output longint s);
    longint r;
    longint p;
    longint cx;
    longint sy;
    longint ph;
    longint t;
    bit     flip;
    r = ang % ONE_TURN;
    if (r < 0) r += ONE_TURN;
    p = (((r <<< 32) + ONE_TURN / 2) / ONE_TURN) & 64'hFFFF_FFFF;
    flip = 0;
    if ((p >> 30) == 1 || (p >> 30) == 2) begin
      p = (p - 64'h8000_0000) & 64'hFFFF_FFFF;
      flip = 1;
    end
    ph = p[31] ? p - (64'sd1 <<< 32) : p;
    cx = longint'(INV_GAIN);
    sy = 0;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      if (ph >= 0) begin
        t  = cx - (sy >>> i);
        sy = sy + (cx >>> i);
        ph -= arctan_step(i);
      end else begin
        t  = cx + (sy >>> i);
        sy = sy - (cx >>> i);
        ph += arctan_step(i);
      end
      cx = t;
    end
    c = flip ? -cx : cx;
    s = flip ? -sy : sy;
  endfunction

  // a' = a*c - b*s, b' = a*s + b*c
  function automatic void spin_pair(inout longint a, inout longint b,
                                    input longint c, input longint s,
                                    inout logic sat);
    longint na;
    longint nb;
    na = scale_q30(a, c) - scale_q30(b, s);
    nb = scale_q30(a, s) + scale_q30(b, c);
    a = clip_coord(na, sat);
    b = clip_coord(nb, sat);
  endfunction

  function automatic rotated_t rotate_point(input axis_e ax, input logic [ANGLE_W-1:0] ang,
      input logic [COORD_WIDTH-1:0] px, input logic [COORD_WIDTH-1:0] py,
      input logic [COORD_WIDTH-1:0] pz);
    rotated_t res;
    longint   x;
    longint   y;
    longint   z;
    longint   c;
    longint   s;
    logic     sat;
    x = longint'($signed(px));
    y = longint'($signed(py));
    z = longint'($signed(pz));
    sat = 1'b0;
    if (ax != AXIS_NONE) begin
      cordic_trig(longint'($signed(ang)), c, s);
      case (ax)
        AXIS_X: spin_pair(y, z, c, s, sat);
        AXIS_Y: spin_pair(z, x, c, s, sat);
        default: spin_pair(x, y, c, s, sat);
      endcase
    end
    res.x = x[COORD_WIDTH-1:0];
    res.y = y[COORD_WIDTH-1:0];
    res.z = z[COORD_WIDTH-1:0];
    res.sat = sat;
    return res;
  endfunction

  // offer one point, hold it until the transfer, record its expected result
  task automatic send_point(input axis_e ax, input int ang, input logic [31:0] px,
                            input logic [31:0] py, input logic [31:0] pz);
    int gap;
    gap = 0;
    if (!tx_quiet) begin
      if ($urandom_range(0, 29) == 0) gap = $urandom_range(10, 40);
      else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    axis_select_i = ax;
    angle_i       = ang[ANGLE_W-1:0];
    coord_x_i     = px;
    coord_y_i     = py;
    coord_z_i     = pz;
    do @(posedge clk_i); while (!in_ready_o);
    rotated_q.push_back(rotate_point(ax, angle_i, px, py, pz));
    points_sent++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                     : 32'h8000_0000 + $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic int rand_angle();
    return int'($urandom_range(0, 2 * 92160)) - 92160;
  endfunction

  task automatic test_extremes();
    send_point(AXIS_Z, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    send_point(AXIS_Z, 11520, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
    send_point(AXIS_X, -11520, 32'h0, 32'h8000_0000, 32'h8000_0000);
    send_point(AXIS_Y, 92160, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0000);
    send_point(AXIS_Y, -92160, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
    send_point(AXIS_X, 46080, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF);
  endtask

  task automatic test_axes_and_quadrants();
    int angs[9] = '{0, 23040, 46080, 69120, -23040, -46080, 1, -1, 34560};
    foreach (angs[i])
      send_point(axis_e'(i % 3), angs[i], 32'h0003_0000, 32'hFFFE_8000, 32'h0000_C000);
  endtask

  task automatic test_passthrough();
    send_point(AXIS_NONE, 11520, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_AAAA);
    send_point(AXIS_NONE, -92160, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000);
    send_point(AXIS_NONE, 131071, 32'hAAAA_5555, 32'h1, 32'h7FFF_FFFF);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      tx_quiet = (i % 200) >= 160;
      rx_quiet = tx_quiet;
      send_point(axis_e'($urandom_range(0, 3)), rand_angle(),
                 rand_coord(), rand_coord(), rand_coord());
    end
    tx_quiet = 0;
    rx_quiet = 0;
  endtask

  // stall the output long enough that the pipeline fills and blocks input
  task automatic test_backpressure();
    tx_quiet = 1;
    rx_hold  = 150;
    for (int i = 0; i < 50; i++)
      send_point(axis_e'($urandom_range(0, 2)), rand_angle(),
                 rand_coord(), rand_coord(), rand_coord());
    tx_quiet = 0;
  endtask

  // hold off new points until every outstanding result has come back
  task automatic test_drain_pause();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (rotated_q.size() == 0);
    test_random(10);
  endtask

  // output side: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    static int stall = 0;
    if (rx_hold > 0) begin
      out_ready_i = 1'b0;
      rx_hold--;
    end else if (stall > 0) begin
      out_ready_i = 1'b0;
      stall--;
    end else begin
      out_ready_i = 1'b1;
      if (!rx_quiet) begin
        if ($urandom_range(0, 39) == 0) stall = $urandom_range(10, 40);
        else if ($urandom_range(0, 4) == 0) stall = $urandom_range(1, 3);
      end
    end
  end

  // compare every transfer with the oldest expected result
  always @(posedge clk_i) begin
    rotated_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rotated_q.size() == 0) begin
        $error("result with no point outstanding");
        errors++;
      end else begin
        exp_r = rotated_q.pop_front();
        points_checked++;
        if (saturated_o) sat_seen++;
        if (rot_x_o !== exp_r.x) begin
          $error("rot_x expected %h got %h", exp_r.x, rot_x_o);
          errors++;
        end
        if (rot_y_o !== exp_r.y) begin
          $error("rot_y expected %h got %h", exp_r.y, rot_y_o);
          errors++;
        end
        if (rot_z_o !== exp_r.z) begin
          $error("rot_z expected %h got %h", exp_r.z, rot_z_o);
          errors++;
        end
        if (saturated_o !== exp_r.sat) begin
          $error("saturated expected %b got %b", exp_r.sat, saturated_o);
          errors++;
        end
      end
    end
  end

  // give up if the run hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, rotated_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_extremes();
    test_axes_and_quadrants();
    test_passthrough();
    test_backpressure();
    test_drain_pause();
    test_random(570);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (rotated_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d points over all axes and pass-through, %0d saturated results,",
             points_sent, sat_seen);
    $display("%0d results checked in %0d cycles with random and long output stalls",
             points_checked, cycle_count);
    if (errors == 0 && rotated_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
